// File: sv/dcm_pkg.sv
package dcm_pkg;

  // Number of driven wheels. Even indices are on the left, odd on the right.
  localparam int WHEELS  = 4;
  localparam int WHEEL_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int LEFT_CNT  = (WHEELS + 1) / 2;
  localparam int RIGHT_CNT = WHEELS / 2;

  // round(pi/30 * 2^32): RPM to rad/s.
  localparam logic [28:0] PI30 = 29'd449767923;
  localparam logic signed [15:0] DUTY_ONE = 16'sd16384;

  localparam logic [1:0] FUNC_FWD  = 2'd0;
  localparam logic [1:0] FUNC_TURN = 2'd1;
  localparam logic [1:0] FUNC_PAIR = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  localparam logic [2:0] REG_GEAR = 3'd0;
  localparam logic [2:0] REG_KT   = 3'd1;
  localparam logic [2:0] REG_VBAT = 3'd2;
  localparam logic [2:0] REG_COND = 3'd3;
  localparam logic [2:0] REG_LIM  = 3'd4;
  localparam logic [2:0] REG_DEAD = 3'd5;

  // Operand register source.
  localparam logic [2:0] XS_KEEP  = 3'd0;
  localparam logic [2:0] XS_PI30  = 3'd1;
  localparam logic [2:0] XS_ACC   = 3'd2;
  localparam logic [2:0] XS_DUTY  = 3'd3;
  localparam logic [2:0] XS_CLAMP = 3'd4;

  // Multiplier second operand.
  localparam logic [2:0] BS_SPEED = 3'd0;
  localparam logic [2:0] BS_GEAR  = 3'd1;
  localparam logic [2:0] BS_KT    = 3'd2;
  localparam logic [2:0] BS_VBAT  = 3'd3;
  localparam logic [2:0] BS_COND  = 3'd4;

  // Accumulator operation.
  localparam logic [1:0] MOP_NOP  = 2'd0;
  localparam logic [1:0] MOP_MULH = 2'd1;
  localparam logic [1:0] MOP_MULL = 2'd2;
  localparam logic [1:0] MOP_SUB  = 2'd3;

  // Sequencer action.
  localparam logic [1:0] SEQ_NEXT  = 2'd0;
  localparam logic [1:0] SEQ_WAIT  = 2'd1;
  localparam logic [1:0] SEQ_STORE = 2'd2;
  localparam logic [1:0] SEQ_DONE  = 2'd3;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_LOOP = 5'd1;
  localparam logic [PC_W-1:0] PC_LAST = 5'd17;

  typedef struct packed {
    logic [2:0] xsel;
    logic       tload;
    logic [2:0] bsel;
    logic [1:0] mop;
    logic [4:0] shamt;
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t   dp;
    logic [1:0] seq;
  } uword_t;

  function automatic uword_t uw(input logic [2:0] xsel, input logic tload,
                                input logic [2:0] bsel, input logic [1:0] mop,
                                input logic [4:0] shamt, input logic [1:0] seq);
    uword_t w;
    w.dp.xsel  = xsel;
    w.dp.tload = tload;
    w.dp.bsel  = bsel;
    w.dp.mop   = mop;
    w.dp.shamt = shamt;
    w.seq      = seq;
    return w;
  endfunction

  // Tick program. Every wide product is taken in two halves of the operand
  // register: MULH on the signed upper half, MULL on the unsigned lower half.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      5'd0:  w = uw(XS_KEEP,  1'b0, BS_SPEED, MOP_NOP,  5'd0,  SEQ_WAIT);
      5'd1:  w = uw(XS_PI30,  1'b0, BS_SPEED, MOP_MULH, 5'd0,  SEQ_NEXT);
      5'd2:  w = uw(XS_KEEP,  1'b0, BS_SPEED, MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd3:  w = uw(XS_ACC,   1'b0, BS_GEAR,  MOP_MULH, 5'd0,  SEQ_NEXT);
      5'd4:  w = uw(XS_KEEP,  1'b0, BS_GEAR,  MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd5:  w = uw(XS_ACC,   1'b0, BS_KT,    MOP_MULH, 5'd27, SEQ_NEXT);
      5'd6:  w = uw(XS_KEEP,  1'b0, BS_KT,    MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd7:  w = uw(XS_DUTY,  1'b1, BS_VBAT,  MOP_MULH, 5'd10, SEQ_NEXT);
      5'd8:  w = uw(XS_KEEP,  1'b0, BS_VBAT,  MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd9:  w = uw(XS_KEEP,  1'b0, BS_SPEED, MOP_SUB,  5'd0,  SEQ_NEXT);
      5'd10: w = uw(XS_ACC,   1'b0, BS_COND,  MOP_MULH, 5'd0,  SEQ_NEXT);
      5'd11: w = uw(XS_KEEP,  1'b0, BS_COND,  MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd12: w = uw(XS_ACC,   1'b0, BS_KT,    MOP_MULH, 5'd14, SEQ_NEXT);
      5'd13: w = uw(XS_KEEP,  1'b0, BS_KT,    MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd14: w = uw(XS_CLAMP, 1'b0, BS_GEAR,  MOP_MULH, 5'd20, SEQ_NEXT);
      5'd15: w = uw(XS_KEEP,  1'b0, BS_GEAR,  MOP_MULL, 5'd0,  SEQ_NEXT);
      5'd16: w = uw(XS_KEEP,  1'b0, BS_SPEED, MOP_NOP,  5'd8,  SEQ_STORE);
      default: w = uw(XS_KEEP, 1'b0, BS_SPEED, MOP_NOP, 5'd0, SEQ_DONE);
    endcase
    return w;
  endfunction

endpackage

// File: sv/dcm_datapath.sv
module dcm_datapath import dcm_pkg::*; (
  input  logic                clk,
  input  dp_ctrl_t            ctrl,
  input  logic signed [15:0]  speed,
  input  logic signed [15:0]  duty,
  input  logic [15:0]         gear_scale,
  input  logic [15:0]         torque_constant,
  input  logic [15:0]         supply_volts,
  input  logic [15:0]         winding_conductance,
  input  logic [15:0]         torque_limit,
  output logic signed [23:0]  wheel_torque
);

  logic signed [63:0] acc;
  logic signed [63:0] acc_next;
  logic signed [47:0] x;
  logic signed [47:0] xin;
  logic signed [47:0] t;
  logic signed [63:0] sh;
  logic signed [63:0] lim_pos;
  logic signed [63:0] lim_neg;
  logic signed [47:0] clamped;
  logic signed [24:0] a_op;
  logic signed [16:0] b_op;
  logic signed [41:0] prod;
  logic signed [63:0] prod_ext;

  // Arithmetic right shift floors, as the fixed-point scaling requires.
  assign sh      = acc >>> ctrl.shamt;
  assign lim_pos = $signed({48'd0, torque_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sh > lim_pos) begin
      clamped = lim_pos[47:0];
    end else if (sh < lim_neg) begin
      clamped = lim_neg[47:0];
    end else begin
      clamped = sh[47:0];
    end
  end

  always_comb begin
    unique case (ctrl.xsel)
      XS_KEEP:  xin = x;
      XS_PI30:  xin = {19'd0, PI30};
      XS_ACC:   xin = sh[47:0];
      XS_DUTY:  xin = {{32{duty[15]}}, duty};
      XS_CLAMP: xin = clamped;
      default:  xin = x;
    endcase
  end

  always_comb begin
    unique case (ctrl.bsel)
      BS_SPEED: b_op = {speed[15], speed};
      BS_GEAR:  b_op = {1'b0, gear_scale};
      BS_KT:    b_op = {1'b0, torque_constant};
      BS_VBAT:  b_op = {1'b0, supply_volts};
      BS_COND:  b_op = {1'b0, winding_conductance};
      default:  b_op = {1'b0, gear_scale};
    endcase
  end

  assign a_op     = (ctrl.mop == MOP_MULH) ? {xin[47], xin[47:24]} : {1'b0, xin[23:0]};
  assign prod     = a_op * b_op;
  assign prod_ext = {{22{prod[41]}}, prod};

  always_comb begin
    unique case (ctrl.mop)
      MOP_NOP:  acc_next = acc;
      MOP_MULH: acc_next = prod_ext;
      MOP_MULL: acc_next = (acc <<< 24) + prod_ext;
      MOP_SUB:  acc_next = acc - {{16{t[47]}}, t};
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    x   <= xin;
    if (ctrl.tload) begin
      t <= sh[47:0];
    end
  end

  always_comb begin
    if (sh > 64'sd8388607) begin
      wheel_torque = 24'sh7FFFFF;
    end else if (sh < -64'sd8388608) begin
      wheel_torque = 24'sh800000;
    end else begin
      wheel_torque = sh[23:0];
    end
  end

endmodule

// File: sv/dc_motor_torque_model.sv
// Channel  Handshake            Payload
// input    in_valid / in_ready  func, ctrl_a, ctrl_b, speed_front_left .. speed_rear_right
// output   out_valid/ out_ready torque_front_left .. torque_rear_right, action_left/right
// config   cfg_valid/ cfg_ready cfg_index, cfg_data
//
// A command transaction (forward, turn, pair) updates the duty accumulators. A tick runs
// a microcoded program: per wheel, seven wide products each take two passes through the
// one 25 x 17 multiplier, plus a subtract and a store step. No input is taken while it
// runs, and its first step waits while an earlier result is still unclaimed. Synchronous
// active-high reset restores the register defaults and clears the accumulators.
// Config never stalls.
module dc_motor_torque_model import dcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [15:0] ctrl_a,
  input  logic signed [15:0] ctrl_b,
  input  logic signed [15:0] speed_front_left,
  input  logic signed [15:0] speed_front_right,
  input  logic signed [15:0] speed_rear_left,
  input  logic signed [15:0] speed_rear_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] torque_front_left,
  output logic signed [23:0] torque_front_right,
  output logic signed [23:0] torque_rear_left,
  output logic signed [23:0] torque_rear_right,
  output logic signed [15:0] action_left,
  output logic signed [15:0] action_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Configuration registers.
  logic [15:0] gear_scale;
  logic [15:0] torque_constant;
  logic [15:0] supply_volts;
  logic [15:0] winding_conductance;
  logic [15:0] torque_limit;
  logic [14:0] dead_zone_duty;

  logic                      state;
  logic [PC_W-1:0]           pc;
  logic [WHEEL_W-1:0]        wheel;
  logic signed [15:0]        duty [WHEELS];
  logic signed [15:0]        spd [WHEELS];
  logic signed [15:0]        speed_in [4];
  logic signed [23:0]        tq_out [WHEELS];
  logic signed [16:0]        lsum;
  logic signed [16:0]        rsum;
  logic signed [16:0]        act_l;
  logic signed [16:0]        act_r;
  uword_t                    uword;
  logic signed [15:0]        duty_raw;
  logic signed [15:0]        duty_cur;
  logic signed [15:0]        spd_cur;
  logic [14:0]               duty_abs;
  logic                      dead;
  logic signed [23:0]        wheel_torque;
  logic                      in_take;
  logic                      last_wheel;
  logic                      duty_zero;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;
  assign uword     = ucode(pc);
  assign last_wheel = (wheel == WHEEL_W'(WHEELS - 1));

  assign speed_in[0] = speed_front_left;
  assign speed_in[1] = speed_front_right;
  assign speed_in[2] = speed_rear_left;
  assign speed_in[3] = speed_rear_right;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // The duty of the wheel being worked on, clamped to plus or minus one.
  assign duty_raw = duty[wheel];
  assign spd_cur  = spd[wheel];

  always_comb begin
    if (duty_raw > DUTY_ONE) begin
      duty_cur = DUTY_ONE;
    end else if (duty_raw < -DUTY_ONE) begin
      duty_cur = -DUTY_ONE;
    end else begin
      duty_cur = duty_raw;
    end
  end

  assign duty_abs = duty_cur[15] ? 15'(-duty_cur) : duty_cur[14:0];

  // A stopped motor inside the dead zone produces no torque at all. The motor
  // is stopped exactly when the gear-scaled speed is zero.
  assign dead = ((spd_cur == 16'sd0) || (gear_scale == 16'd0))
                && (duty_abs <= dead_zone_duty);

  dcm_datapath u_datapath (
    .clk                 (clk),
    .ctrl                (uword.dp),
    .speed               (spd_cur),
    .duty                (duty_cur),
    .gear_scale          (gear_scale),
    .torque_constant     (torque_constant),
    .supply_volts        (supply_volts),
    .winding_conductance (winding_conductance),
    .torque_limit        (torque_limit),
    .wheel_torque        (wheel_torque)
  );

  // Configuration writes. Indices beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gear_scale          <= 16'd256;
      torque_constant     <= 16'd6554;
      supply_volts        <= 16'd3072;
      winding_conductance <= 16'd256;
      torque_limit        <= 16'd4096;
      dead_zone_duty      <= 15'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GEAR: gear_scale          <= cfg_data;
        REG_KT:   torque_constant     <= cfg_data;
        REG_VBAT: supply_volts        <= cfg_data;
        REG_COND: winding_conductance <= cfg_data;
        REG_LIM:  torque_limit        <= cfg_data;
        REG_DEAD: dead_zone_duty      <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // Duty accumulators. Commands saturate each wheel's sum to 16 bits; the
  // end of a tick clears them all.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        duty[i] <= '0;
      end
    end else if (in_take && (func != FUNC_TICK)) begin
      for (int i = 0; i < WHEELS; i++) begin
        unique case (func)
          FUNC_FWD:  duty[i] <= sat16(18'(duty[i]) + 18'(ctrl_a));
          FUNC_TURN: duty[i] <= ((i % 2) == 0) ? sat16(18'(duty[i]) + 18'(ctrl_a))
                                               : sat16(18'(duty[i]) - 18'(ctrl_a));
          FUNC_PAIR: duty[i] <= ((i % 2) == 0) ? sat16(18'(duty[i]) + 18'(ctrl_a))
                                               : sat16(18'(duty[i]) + 18'(ctrl_b));
          default:   duty[i] <= duty[i];
        endcase
      end
    end else if ((state == ST_RUN) && (uword.seq == SEQ_DONE)) begin
      for (int i = 0; i < WHEELS; i++) begin
        duty[i] <= '0;
      end
    end
  end

  // Sequencer: program counter, wheel counter and the jump back to the top of
  // the per-wheel loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      wheel     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE) begin
        if (in_take && (func == FUNC_TICK)) begin
          state <= ST_RUN;
          pc    <= '0;
          wheel <= '0;
        end
      end else begin
        unique case (uword.seq)
          SEQ_NEXT: pc <= pc + 1'b1;
          SEQ_WAIT: begin
            if (!out_valid) begin
              pc <= pc + 1'b1;
            end
          end
          SEQ_STORE: begin
            if (last_wheel) begin
              pc <= pc + 1'b1;
            end else begin
              pc    <= PC_LOOP;
              wheel <= wheel + 1'b1;
            end
          end
          SEQ_DONE: begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
          end
          default: pc <= pc;
        endcase
      end
    end
  end

  // Speeds are captured with the tick transaction; torques and side sums are
  // built up wheel by wheel while the output register is free.
  always_ff @(posedge clk) begin
    if (in_take && (func == FUNC_TICK)) begin
      for (int i = 0; i < WHEELS; i++) begin
        spd[i] <= speed_in[i];
      end
      lsum <= '0;
      rsum <= '0;
    end
    if ((state == ST_RUN) && (uword.seq == SEQ_STORE)) begin
      tq_out[wheel] <= dead ? 24'sd0 : wheel_torque;
      if (wheel[0] == 1'b0) begin
        lsum <= lsum + 17'(duty_cur);
      end else begin
        rsum <= rsum + 17'(duty_cur);
      end
    end
    if ((state == ST_RUN) && (uword.seq == SEQ_DONE)) begin
      action_left  <= act_l[15:0];
      action_right <= act_r[15:0];
    end
  end

  // A side with two wheels reports the floored mean, a single wheel its duty.
  assign act_l = (LEFT_CNT == 2) ? (lsum >>> 1) : lsum;
  assign act_r = (RIGHT_CNT == 2) ? (rsum >>> 1) : rsum;

  assign torque_front_left  = tq_out[0];
  assign torque_front_right = tq_out[1];

  generate
    if (WHEELS > 2) begin : g_rear_left
      assign torque_rear_left = tq_out[2];
    end else begin : g_no_rear_left
      assign torque_rear_left = '0;
    end
    if (WHEELS > 3) begin : g_rear_right
      assign torque_rear_right = tq_out[3];
    end else begin : g_no_rear_right
      assign torque_rear_right = '0;
    end
  endgenerate

  always_comb begin
    duty_zero = 1'b1;
    for (int i = 0; i < WHEELS; i++) begin
      if (duty[i] != 16'sd0) begin
        duty_zero = 1'b0;
      end
    end
  end

  // A result only appears at the end of the tick program.
  a_result_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past((state == ST_RUN) && (uword.seq == SEQ_DONE)))
    else $error("result raised outside the end of a tick");

  // The program counter never leaves the program while it runs.
  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (pc <= PC_LAST))
    else $error("program counter out of range");

  // The wheel counter stays on a fitted wheel.
  a_wheel_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (wheel <= WHEEL_W'(WHEELS - 1)))
    else $error("wheel counter out of range");

  // Every tick leaves the duty accumulators cleared.
  a_duty_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && (uword.seq == SEQ_DONE)) |=> duty_zero)
    else $error("duty accumulators not cleared after tick");

  // Side actions are means of clamped duties and stay within plus or minus one.
  a_action_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((action_left >= -DUTY_ONE) && (action_left <= DUTY_ONE)
                   && (action_right >= -DUTY_ONE) && (action_right <= DUTY_ONE)))
    else $error("side action out of range");

endmodule
